FILE: hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants of the bit-list packer store.
// ----------------------------------------------------------------------------
package bls_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int TOP_BIT       = 7;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// One appended group laid over the current byte and the byte after it.
	typedef struct packed {
		logic [7:0] head;
		logic [7:0] tail;
	} span_t;

endpackage

FILE: hw/rtl/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// The read data holds until the next read is issued.
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/bls_span.sv
// ----------------------------------------------------------------------------
// bls_span
// Places an appended group of up to eight bits over two consecutive bytes.
// ----------------------------------------------------------------------------
module bls_span (
	input  logic          lsb_first,
	input  logic [2:0]    offset,
	input  logic [3:0]    count,
	input  logic [7:0]    value,
	output bls_pkg::span_t span
);
	import bls_pkg::*;

	logic [15:0] masked;
	logic [4:0]  msb_shift;
	logic [15:0] word;

	always_comb begin
		masked    = 16'(value) & ((16'd1 << count) - 16'd1);
		// In MSB order the first bit sits at word bit 15 - offset.
		msb_shift = 5'd16 - 5'(offset) - 5'(count);
		word      = lsb_first ? (masked << offset) : (masked << msb_shift);
		if (lsb_first) begin
			span.head = word[7:0];
			span.tail = word[15:8];
		end else begin
			span.head = word[15:8];
			span.tail = word[7:0];
		end
	end

endmodule

FILE: hw/rtl/bit_list_packer_store.sv
// ----------------------------------------------------------------------------
// bit_list_packer_store
// Bit-list store: appends groups of 1 to 8 bits into a byte RAM and reads
// single bits back by index, in MSB-first or LSB-first order.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes through the registered RAM read in stage
// one and then the output register; stage one stalls while the output waits.
// Throughput: one word per cycle unless the output stalls; the byte RAM is
// touched at most once per word, either one write or one read.
// Reset: length, partial byte, mode and valids clear at once; the RAM keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module bit_list_packer_store #(
	parameter int MAX_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  value,
	input  logic [3:0]  nbits,
	input  logic [11:0] index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        bit_res,
	output logic [12:0] length,
	output logic [1:0]  status
);
	import bls_pkg::*;

	// The length counter must hold the full capacity in bits; the compare
	// width must also cover the twelve-bit read index.
	localparam int CAP    = MAX_BYTES * BITS_PER_BYTE;
	localparam int LEN_W  = $clog2(CAP + 1);
	localparam int AW     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CMP_W  = (LEN_W > 12) ? LEN_W : 12;
	localparam logic [LEN_W:0] CAP_L = (LEN_W + 1)'(CAP);

	// Architectural state. The byte at position len_q / 8 is held in cur_q
	// while it is only partly filled; it goes to the RAM once complete.
	logic             lsb_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       cur_q;

	// Stage one: the item after acceptance, waiting for RAM read data.
	logic             v_s1;
	logic             rd_s1;
	logic             use_cur_s1;
	logic [7:0]       cur_s1;
	logic [2:0]       place_s1;
	status_t          status_s1;
	logic [12:0]      len_s1;

	// Output register.
	logic             out_valid_q;
	logic             bit_res_q;
	logic [12:0]      length_q;
	status_t          status_q;

	logic             accept;
	logic             adv;
	logic [3:0]       count_sat;
	logic [2:0]       offset;
	logic [LEN_W:0]   next_len;
	logic             full;
	logic [7:0]       base;
	logic [7:0]       head;
	logic             complete;
	logic             do_append;
	span_t            span;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] len_ext;
	logic             in_range;
	logic             use_cur;
	logic [2:0]       place;
	logic             ram_wr_en;
	logic             ram_rd_en;
	logic [7:0]       ram_rd_data;
	logic [7:0]       byte_sel;
	status_t          status_new;
	logic [LEN_W-1:0] len_after;

	// Stage one moves on when the output register is empty or being taken;
	// a new word may enter whenever stage one is empty or moving on.
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Append path. A bit count beyond eight is treated as eight, and zero
	// appends nothing.
	assign count_sat = (nbits > 4'(BITS_PER_BYTE)) ? 4'(BITS_PER_BYTE) : nbits;
	assign offset    = len_q[2:0];
	assign next_len  = {1'b0, len_q} + (LEN_W + 1)'(count_sat);
	assign full      = next_len > CAP_L;

	bls_span u_span (
		.lsb_first (lsb_q),
		.offset    (offset),
		.count     (count_sat),
		.value     (value),
		.span      (span)
	);

	// A fresh byte starts out clear; otherwise new bits are ORed into the
	// partial byte.
	assign base      = (offset == 3'd0) ? 8'd0 : cur_q;
	assign head      = base | span.head;
	assign complete  = (4'(offset) + count_sat) >= 4'(BITS_PER_BYTE);
	assign do_append = accept && (cmd == CMD_APPEND) && !full;
	assign ram_wr_en = do_append && complete;

	// Read path. A read that lands in the partial byte is served from cur_q,
	// since that byte has not reached the RAM yet.
	assign idx_ext   = CMP_W'(index);
	assign len_ext   = CMP_W'(len_q);
	assign in_range  = idx_ext < len_ext;
	assign use_cur   = idx_ext[CMP_W-1:3] == len_ext[CMP_W-1:3];
	assign place     = lsb_q ? index[2:0] : (3'(TOP_BIT) - index[2:0]);
	assign ram_rd_en = accept && (cmd == CMD_READ);

	bls_ram #(
		.WIDTH (BITS_PER_BYTE),
		.DEPTH (MAX_BYTES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (len_q[AW+2:3]),
		.wr_data (head),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_ext[AW+2:3]),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		len_after = len_q;
		unique case (cmd)
			CMD_APPEND: begin
				status_new = full ? ST_FULL : ST_OK;
				if (!full) begin
					len_after = next_len[LEN_W-1:0];
				end
			end
			CMD_READ: begin
				status_new = in_range ? ST_OK : ST_RANGE;
			end
			default: begin
				status_new = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_q <= 1'b0;
			len_q <= '0;
			cur_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				lsb_q <= cfg_wdata;
			end
			if (do_append) begin
				len_q <= next_len[LEN_W-1:0];
				// On a completed byte the spill-over becomes the new partial byte.
				cur_q <= complete ? span.tail : head;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1      <= (cmd == CMD_READ);
			use_cur_s1 <= use_cur;
			cur_s1     <= cur_q;
			place_s1   <= place;
			status_s1  <= status_new;
			len_s1     <= 13'(len_after);
		end
	end

	// The RAM data only changes on a read issue, which only happens together
	// with a new word entering stage one, so it stays put while stage one
	// stalls.
	assign byte_sel = use_cur_s1 ? cur_s1 : ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bit_res_q <= rd_s1 && (status_s1 == ST_OK) && byte_sel[place_s1];
			length_q  <= len_s1;
			status_q  <= status_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign bit_res   = bit_res_q;
	assign length    = length_q;
	assign status    = status_q;

endmodule
